/* hw/rtl/lsc_pkg.sv */
// Shared types, constants and helper functions for the line segment clipper.
package lsc_pkg;

	// Outcode bits.
	localparam logic [3:0] OC_LEFT   = 4'd1;
	localparam logic [3:0] OC_RIGHT  = 4'd2;
	localparam logic [3:0] OC_BOTTOM = 4'd4;
	localparam logic [3:0] OC_TOP    = 4'd8;

	// Configuration register indexes.
	localparam logic [1:0] REG_X_MIN = 2'd0;
	localparam logic [1:0] REG_X_MAX = 2'd1;
	localparam logic [1:0] REG_Y_MIN = 2'd2;
	localparam logic [1:0] REG_Y_MAX = 2'd3;

	localparam int CLIP_PASSES = 4;
	localparam int QUOT_W      = 32;
	localparam int DIV_STEPS   = 2;
	localparam int DIV_STAGES  = QUOT_W / DIV_STEPS;

	typedef struct packed {
		logic signed [15:0] x_min;
		logic signed [15:0] x_max;
		logic signed [15:0] y_min;
		logic signed [15:0] y_max;
	} lsc_win_t;

	// Segment state as it moves from pass to pass.
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] bx;
		logic signed [15:0] by;
		logic [3:0]         ca;
		logic [3:0]         cb;
		logic               done;
		logic               accept;
	} lsc_item_t;

	// Control of the clip operation inside one pass.
	typedef struct packed {
		logic               act;
		logic               sel_a;
		logic               xclip;
		logic signed [15:0] fixed;
		logic signed [15:0] base;
		logic               neg;
		logic               dz;
	} lsc_op_t;

	// Divider working set: partial remainder and dividend/quotient shift word.
	typedef struct packed {
		logic [17:0]       rem;
		logic [QUOT_W-1:0] nq;
	} lsc_div_t;

	function automatic logic [3:0] outcode(logic signed [15:0] x, logic signed [15:0] y,
			lsc_win_t w);
		logic [3:0] c;
		c = '0;
		if (y > w.y_max)
			c = c | OC_TOP;
		else if (y < w.y_min)
			c = c | OC_BOTTOM;
		if (x > w.x_max)
			c = c | OC_RIGHT;
		else if (x < w.x_min)
			c = c | OC_LEFT;
		return c;
	endfunction

	// A few restoring division steps, one quotient bit each.
	function automatic lsc_div_t div_step(lsc_div_t a, logic [16:0] den);
		lsc_div_t   r;
		logic [17:0] t;
		r = a;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r.rem[16:0], r.nq[QUOT_W-1]};
			r.nq = {r.nq[QUOT_W-2:0], 1'b0};
			if (t >= {1'b0, den}) begin
				t = t - {1'b0, den};
				r.nq[0] = 1'b1;
			end
			r.rem = t;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/line_segment_clipper_core.sv */
// Top level of the Cohen-Sutherland line segment clipper pipeline.
//
//   Channel   Signals                                  Direction
//   request   in_valid, in_stall, start_*, end_*       in  (stall out)
//   result    out_valid, out_stall, accepted, clipped_* out (stall in)
//   config    cfg_we, cfg_index, cfg_data              in
//
// A new segment can enter every cycle while no held result stalls the pipeline.
// The path runs through the input stage, four passes of 20 stages each and the
// output register. Each pass holds its 16-stage divider, two quotient bits per stage.
// Reset clears all valid bits and loads the default 640x480 window.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module line_segment_clipper_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic signed [15:0] clipped_start_x,
	output logic signed [15:0] clipped_start_y,
	output logic signed [15:0] clipped_end_x,
	output logic signed [15:0] clipped_end_y,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import lsc_pkg::*;

	lsc_win_t  win_q;
	logic      adv;
	logic      pv   [0:CLIP_PASSES];
	lsc_item_t pitem[0:CLIP_PASSES];
	lsc_item_t in_item;
	lsc_item_t last;

	// The pipeline moves unless a finished result is held.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.x_min <= 16'sd0;
			win_q.x_max <= 16'sd639;
			win_q.y_min <= 16'sd0;
			win_q.y_max <= 16'sd479;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_MIN: win_q.x_min <= cfg_data;
				REG_X_MAX: win_q.x_max <= cfg_data;
				REG_Y_MIN: win_q.y_min <= cfg_data;
				REG_Y_MAX: win_q.y_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: capture endpoints and their outcodes.
	always_comb begin
		in_item        = '0;
		in_item.ax     = start_x;
		in_item.ay     = start_y;
		in_item.bx     = end_x;
		in_item.by     = end_y;
		in_item.ca     = outcode(start_x, start_y, win_q);
		in_item.cb     = outcode(end_x, end_y, win_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv[0] <= 1'b0;
		end else if (adv) begin
			pv[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pitem[0] <= in_item;
		end
	end

	// Four clip passes in a row.
	for (genvar p = 0; p < CLIP_PASSES; p++) begin : g_pass
		lsc_pass u_pass (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.win     (win_q),
			.in_v    (pv[p]),
			.in_item (pitem[p]),
			.out_v   (pv[p+1]),
			.out_item(pitem[p+1])
		);
	end

	// Output register: an unresolved segment is accepted only if fully inside.
	assign last = pitem[CLIP_PASSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= pv[CLIP_PASSES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted        <= last.done ? last.accept :
			                   (last.ca == 4'd0 && last.cb == 4'd0);
			clipped_start_x <= last.ax;
			clipped_start_y <= last.ay;
			clipped_end_x   <= last.bx;
			clipped_end_y   <= last.by;
		end
	end

	// An accepted segment lies wholly inside the window.
	a_accept_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |->
		(outcode(clipped_start_x, clipped_start_y, win_q) == 4'd0 &&
		 outcode(clipped_end_x, clipped_end_y, win_q) == 4'd0))
		else $error("accepted segment has an endpoint outside the window");

	// A held result freezes the pipeline entry.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(pv[0]) && $stable(pv[CLIP_PASSES]))
		else $error("pipeline moved while the result was stalled");

	// The request side is stalled exactly when a held result blocks the pipeline.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a held result");

endmodule

/* hw/rtl/lsc_pass.sv */
// One clip pass: decide, multiply, pipelined divide, move the endpoint.
module lsc_pass (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lsc_pkg::lsc_win_t  win,
	input  logic               in_v,
	input  lsc_pkg::lsc_item_t in_item,
	output logic               out_v,
	output lsc_pkg::lsc_item_t out_item
);
	import lsc_pkg::*;

	lsc_item_t          dec_item;
	lsc_op_t            dec_op;
	logic signed [16:0] dec_d, dec_num, dec_den;
	logic [3:0]         co;

	logic               v_s1, v_s2;
	lsc_item_t          item_s1, item_s2;
	lsc_op_t            op_s1, op_s2;
	logic signed [16:0] d_s1, num_s1, den_s1, den_s2;
	logic signed [33:0] prod_s2;

	logic [33:0]        pmag;
	logic [16:0]        dmag;
	lsc_op_t            op_div0;

	logic               dv_v_s   [0:DIV_STAGES];
	lsc_item_t          dv_item_s[0:DIV_STAGES];
	lsc_op_t            dv_op_s  [0:DIV_STAGES];
	logic [16:0]        dv_den_s [0:DIV_STAGES];
	lsc_div_t           dv_s     [0:DIV_STAGES];

	logic [15:0]        q16;
	logic signed [15:0] res, nx, ny;
	lsc_item_t          fin_item;
	lsc_op_t            fop;

	// Decide what this pass does and set up the intersection operands.
	always_comb begin
		dec_item = in_item;
		dec_op   = '0;
		dec_d    = '0;
		dec_num  = '0;
		dec_den  = '0;
		co       = (in_item.ca != 4'd0) ? in_item.ca : in_item.cb;
		if (!in_item.done) begin
			if (in_item.ca == 4'd0 && in_item.cb == 4'd0) begin
				dec_item.accept = 1'b1;
				dec_item.done   = 1'b1;
			end else if ((in_item.ca & in_item.cb) != 4'd0) begin
				dec_item.done = 1'b1;
			end else begin
				dec_op.act   = 1'b1;
				dec_op.sel_a = (in_item.ca != 4'd0);
				dec_op.xclip = ((co & (OC_RIGHT | OC_LEFT)) != 4'd0);
			end
		end
		if ((co & (OC_RIGHT | OC_LEFT)) != 4'd0) begin
			dec_op.fixed = ((co & OC_RIGHT) != 4'd0) ? win.x_max : win.x_min;
			dec_op.base  = in_item.ay;
			dec_d   = 17'(in_item.by) - 17'(in_item.ay);
			dec_num = 17'(dec_op.fixed) - 17'(in_item.ax);
			dec_den = 17'(in_item.bx) - 17'(in_item.ax);
		end else begin
			dec_op.fixed = ((co & OC_TOP) != 4'd0) ? win.y_max : win.y_min;
			dec_op.base  = in_item.ax;
			dec_d   = 17'(in_item.bx) - 17'(in_item.ax);
			dec_num = 17'(dec_op.fixed) - 17'(in_item.ay);
			dec_den = 17'(in_item.by) - 17'(in_item.ay);
		end
	end

	// Stage 1: decision registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= dec_item;
			op_s1   <= dec_op;
			d_s1    <= dec_d;
			num_s1  <= dec_num;
			den_s1  <= dec_den;
		end
	end

	// Stage 2: product of the delta and the distance to the edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_s1;
			op_s2   <= op_s1;
			prod_s2 <= d_s1 * num_s1;
			den_s2  <= den_s1;
		end
	end

	// Stage 3: magnitudes and quotient sign feed the divider.
	always_comb begin
		pmag = prod_s2[33] ? 34'(-prod_s2) : 34'(prod_s2);
		dmag = den_s2[16] ? 17'(-den_s2) : 17'(den_s2);
		op_div0     = op_s2;
		op_div0.neg = prod_s2[33] ^ den_s2[16];
		op_div0.dz  = (den_s2 == 17'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_item_s[0] <= item_s2;
			dv_op_s[0]   <= op_div0;
			dv_den_s[0]  <= dmag;
			dv_s[0]      <= '{rem: '0, nq: pmag[QUOT_W-1:0]};
		end
	end

	// Divider stages, a few quotient bits each.
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_item_s[k] <= dv_item_s[k-1];
				dv_op_s[k]   <= dv_op_s[k-1];
				dv_den_s[k]  <= dv_den_s[k-1];
				dv_s[k]      <= div_step(dv_s[k-1], dv_den_s[k-1]);
			end
		end
	end

	// Final stage: new coordinate, endpoint update and fresh outcode.
	always_comb begin
		fop      = dv_op_s[DIV_STAGES];
		q16      = dv_s[DIV_STAGES].nq[15:0];
		if (fop.dz)
			res = fop.base;
		else if (fop.neg)
			res = fop.base - $signed(q16);
		else
			res = fop.base + $signed(q16);
		nx = fop.xclip ? fop.fixed : res;
		ny = fop.xclip ? res : fop.fixed;
		fin_item = dv_item_s[DIV_STAGES];
		if (fop.act) begin
			if (fop.sel_a) begin
				fin_item.ax = nx;
				fin_item.ay = ny;
				fin_item.ca = outcode(nx, ny, win);
			end else begin
				fin_item.bx = nx;
				fin_item.by = ny;
				fin_item.cb = outcode(nx, ny, win);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= dv_v_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item <= fin_item;
		end
	end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Cohen-Sutherland line segment clipper core.
`timescale 1ns / 1ps

module testbench;
	import lsc_pkg::*;

	typedef struct {
		logic               acc;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} clip_res_t;

	// Scoreboard: predicts the clipped segment and checks the results in order.
	class clip_scoreboard;
		int x_min = 0, x_max = 639, y_min = 0, y_max = 479;
		clip_res_t pending[$];
		int errors = 0;

		function void set_reg(logic [1:0] idx, logic signed [15:0] val);
			case (idx)
				REG_X_MIN: x_min = val;
				REG_X_MAX: x_max = val;
				REG_Y_MIN: y_min = val;
				default:   y_max = val;
			endcase
		endfunction

		function logic [3:0] region(int x, int y);
			logic [3:0] c;
			c = '0;
			if (y > y_max) c |= OC_TOP;
			else if (y < y_min) c |= OC_BOTTOM;
			if (x > x_max) c |= OC_RIGHT;
			else if (x < x_min) c |= OC_LEFT;
			return c;
		endfunction

		// Edge intersection, truncated toward zero, wrapped to 16 bits.
		function int edge_point(int base, int d, int num, int den);
			longint q;
			logic signed [15:0] w;
			q = (den == 0) ? 0 : (longint'(d) * longint'(num)) / longint'(den);
			w = 16'(longint'(base) + q);
			return w;
		endfunction

		function void note_request(int ax, int ay, int bx, int by);
			logic [3:0] ca, cb, co;
			int nx, ny;
			clip_res_t r;
			r.acc = 0;
			ca = region(ax, ay);
			cb = region(bx, by);
			for (int p = 0; p <= CLIP_PASSES; p++) begin
				if (ca == 0 && cb == 0) begin
					r.acc = 1;
					break;
				end
				if ((ca & cb) != 0 || p == CLIP_PASSES) break;
				co = (ca != 0) ? ca : cb;
				if ((co & (OC_RIGHT | OC_LEFT)) != 0) begin
					nx = (co & OC_RIGHT) ? x_max : x_min;
					ny = edge_point(ay, by - ay, nx - ax, bx - ax);
				end else begin
					ny = (co & OC_TOP) ? y_max : y_min;
					nx = edge_point(ax, bx - ax, ny - ay, by - ay);
				end
				if (ca != 0) begin
					ax = nx; ay = ny; ca = region(ax, ay);
				end else begin
					bx = nx; by = ny; cb = region(bx, by);
				end
			end
			r.sx = ax; r.sy = ay; r.ex = bx; r.ey = by;
			pending = {pending, r};
		endfunction

		function void check_result(clip_res_t got);
			clip_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result acc=%0d", $time, got.acc);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.acc !== e.acc || got.sx !== e.sx || got.sy !== e.sy ||
					got.ex !== e.ex || got.ey !== e.ey) begin
				$display({"%0t: mismatch expected acc=%0d (%0d,%0d)-(%0d,%0d)",
					" actual acc=%0d (%0d,%0d)-(%0d,%0d)"},
					$time, e.acc, e.sx, e.sy, e.ex, e.ey,
					got.acc, got.sx, got.sy, got.ex, got.ey);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, accepted, cfg_we;
	logic signed [15:0] start_x, start_y, end_x, end_y;
	logic signed [15:0] clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	clip_scoreboard sb;
	int cycles = 0;
	bit calm = 0;

	line_segment_clipper_core i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Cycle counter with a generous timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("[line_segment_clipper_core] ERROR");
			$finish;
		end
	end

	// Result side: random stall unless calm, check each result as it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{accepted, clipped_start_x, clipped_start_y,
				clipped_end_x, clipped_end_y});
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
	end

	// One register write; the caller drops the write enable afterwards.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_window(int a, int b, int c, int d);
		write_reg(REG_X_MIN, 16'(a));
		write_reg(REG_X_MAX, 16'(b));
		write_reg(REG_Y_MIN, 16'(c));
		write_reg(REG_Y_MAX, 16'(d));
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Send one request; the valid stays high into the next request's cycle.
	task automatic send(int ax, int ay, int bx, int by);
		while (!calm && $urandom_range(99) < 28) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		start_x <= ax; start_y <= ay; end_x <= bx; end_y <= by;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(ax, ay, bx, by);
	endtask

	// Wait until every result is back and the pipeline is empty.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic int coord(int xlo, int xhi);
		case ($urandom_range(9))
			0: return $urandom_range(65535) - 32768;
			1: return ($urandom_range(1)) ? 32767 : -32768;
			default: return $urandom_range(xhi - xlo) + xlo;
		endcase
	endfunction

	task automatic random_batch(int n, int lo, int hi);
		for (int i = 0; i < n; i++)
			send(coord(lo, hi), coord(lo, hi), coord(lo, hi), coord(lo, hi));
	endtask

	initial begin
		sb = new();
		arst_n = 0; in_valid = 0; out_stall = 0; cfg_we = 0;
		cfg_index = REG_X_MIN; cfg_data = 0;
		start_x = 0; start_y = 0; end_x = 0; end_y = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset window, inside, trivial reject, each edge, extremes.
		send(10, 10, 600, 400);
		send(-100, -100, -10, 900);
		send(-50, 240, 700, 240);
		send(320, -50, 320, 900);
		send(-32768, -32768, 32767, 32767);
		send(32767, -32768, -32768, 32767);
		send(-1000, 100, 100, -1000);
		send(700, 500, 700, 500);
		send(0, 0, 639, 479);
		send(-1, 480, 640, -1);
		send(-32768, 0, 32767, 1);
		send(-300, 600, 900, -300);
		drain();

		// Inverted and extreme windows.
		set_window(100, -100, 50, -50);
		send(-200, 0, 200, 0);
		send(0, -200, 0, 200);
		send(-32768, -32768, 32767, 32767);
		random_batch(100, -300, 300);
		drain();
		set_window(-32768, 32767, -32768, 32767);
		random_batch(60, -32768, 32767);
		drain();
		set_window(-32768, -32768, 32767, 32767);
		random_batch(40, -32768, 32767);
		drain();

		// Random windows with random segments around them.
		for (int ph = 0; ph < 8; ph++) begin
			int a, b, c, d;
			a = $urandom_range(2000) - 1000;
			b = a + $urandom_range(1500) - 100;
			c = $urandom_range(2000) - 1000;
			d = c + $urandom_range(1500) - 100;
			set_window(a, b, c, d);
			calm = (ph == 3);
			random_batch(130, -2500, 2500);
			drain();
		end
		calm = 0;
		set_window(0, 639, 0, 479);
		random_batch(50, -1000, 1500);
		drain();

		if (sb.errors == 0)
			$display("[line_segment_clipper_core] OK");
		else
			$display("[line_segment_clipper_core] ERROR");
		$finish;
	end
endmodule
